// ===== hdl/hla_pkg.sv =====
// ----------------------------------------------------------------------------
// hla_pkg: shared types and constants of the Hough line accumulator
// Store geometry, operation codes, queue entry layout and the Q1.14 sine table.
// ----------------------------------------------------------------------------
package hla_pkg;

  localparam int NUM_ANGLES  = 180;
  localparam int RHO_BINS    = 1024;
  localparam int MAX_DIM     = 512;
  localparam int COUNT_BITS  = 16;

  localparam int STORE_CELLS = NUM_ANGLES * RHO_BINS;
  localparam int ADDR_W      = $clog2(STORE_CELLS);
  localparam int ANG_W       = $clog2(NUM_ANGLES);
  localparam int DIM_W       = $clog2(MAX_DIM) + 1;     // config width
  localparam int DELTA_W     = DIM_W + 1;               // signed pixel offset
  localparam int DEG_W       = 9;
  localparam int TRIG_W      = 16;
  localparam int PROD_W      = DELTA_W + TRIG_W;
  localparam int SUM_W       = PROD_W + 1;
  localparam int R_W         = SUM_W - 14;
  localparam int HD_W        = 9;
  localparam int BIN_W       = R_W + 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [1:0] KIND_VOTE  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_HDIAG  = 2'd2;
  localparam logic [1:0] REG_SPARE  = 2'd3;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_VOTE,
    OP_READ,
    OP_CLEAR
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VOTE,
    ST_DRAIN,
    ST_READ,
    ST_RDWAIT,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [HD_W-1:0]  hdiag;
  } cfg_t;

  typedef struct packed {
    op_e                       op;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [ADDR_W-1:0]         addr;
  } entry_t;

  typedef struct packed {
    logic ready;
    logic init;
  } back_stat_t;

  localparam logic [14:0] QSINE [91] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5871,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // Sine of a in Q1.14, a below 360.
  function automatic logic signed [TRIG_W-1:0] sine_q14(input logic [DEG_W-1:0] a);
    logic [DEG_W-1:0] idx;
    logic             neg;
    begin
      neg = 1'b0;
      if (a <= DEG_W'(90)) begin
        idx = a;
      end else if (a <= DEG_W'(180)) begin
        idx = DEG_W'(180) - a;
      end else if (a <= DEG_W'(270)) begin
        idx = a - DEG_W'(180);
        neg = 1'b1;
      end else begin
        idx = DEG_W'(360) - a;
        neg = 1'b1;
      end
      sine_q14 = neg ? -$signed({1'b0, QSINE[idx[6:0]]}) : $signed({1'b0, QSINE[idx[6:0]]});
    end
  endfunction

endpackage

// ===== hdl/hla_ram.sv =====
// ----------------------------------------------------------------------------
// hla_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hla_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/hla_front.sv =====
// ----------------------------------------------------------------------------
// hla_front: command intake and classification
// Decodes each command into an operation, precomputes offsets and the read
// address, and holds it in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module hla_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hla_pkg::cfg_t       cfg_i,
  input  hla_pkg::back_stat_t stat_i,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          kind_i,
  input  logic [8:0]          col_i,
  input  logic [8:0]          row_i,
  input  logic [7:0]          pixel_value_i,
  input  logic [7:0]          angle_index_i,
  input  logic [9:0]          rho_index_i,
  output logic                ent_vld_o,
  output hla_pkg::entry_t     ent_o
);

  hla_pkg::entry_t ent_in;
  hla_pkg::entry_t fifo_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;
  logic            push, pop, rd_ok;

  always_comb begin
    rd_ok = (32'(angle_index_i) < 32'(hla_pkg::NUM_ANGLES)) &&
            ({1'b0, rho_index_i} <= {1'b0, cfg_i.hdiag, 1'b0}) &&
            (32'(rho_index_i) < 32'(hla_pkg::RHO_BINS));
    ent_in.dx = $signed({2'b00, col_i}) - $signed({2'b00, cfg_i.height[hla_pkg::DIM_W-1:1]});
    ent_in.dy = $signed({2'b00, row_i}) - $signed({2'b00, cfg_i.width[hla_pkg::DIM_W-1:1]});
    ent_in.addr = hla_pkg::ADDR_W'(angle_index_i) * hla_pkg::ADDR_W'(hla_pkg::RHO_BINS)
                + hla_pkg::ADDR_W'(rho_index_i);
    unique case (kind_i)
      hla_pkg::KIND_VOTE:  ent_in.op = (pixel_value_i != 8'd0) ? hla_pkg::OP_VOTE
                                                               : hla_pkg::OP_NOP;
      hla_pkg::KIND_READ:  ent_in.op = rd_ok ? hla_pkg::OP_READ : hla_pkg::OP_NOP;
      hla_pkg::KIND_CLEAR: ent_in.op = hla_pkg::OP_CLEAR;
      default:             ent_in.op = hla_pkg::OP_NOP;
    endcase
  end

  assign busy_o    = (cnt_q == 2'd2) || stat_i.init;
  assign push      = start_i && !busy_o;
  assign ent_vld_o = (cnt_q != 2'd0);
  assign pop       = ent_vld_o && stat_i.ready;
  assign ent_o     = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= ent_in;
    end
  end

endmodule

// ===== hdl/hla_back.sv =====
// ----------------------------------------------------------------------------
// hla_back: accumulator execution engine
// Runs the angle sweep through a four-stage read-modify-write pipeline,
// serves cell reads, sweeps the store for clears, and emits results.
// ----------------------------------------------------------------------------
module hla_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  hla_pkg::cfg_t                  cfg_i,
  input  logic                           ent_vld_i,
  input  hla_pkg::entry_t                ent_i,
  output hla_pkg::back_stat_t            stat_o,
  output logic                           done_o,
  output logic [hla_pkg::COUNT_BITS-1:0] cell_count_o,
  output logic                           read_valid_o
);

  hla_pkg::state_e state_q, state_d;
  hla_pkg::entry_t cur_q;
  logic [hla_pkg::ANG_W-1:0]  ang_q, ang_d;
  logic [hla_pkg::ADDR_W-1:0] clr_q, clr_d;
  logic clr_res_q, clr_res_d, init_q, init_d;
  logic take;

  logic res_vld_q, res_vld_d, res_rv_q, res_rv_d;
  logic [hla_pkg::COUNT_BITS-1:0] res_cnt_q, res_cnt_d;

  // sweep pipeline
  logic issue;
  logic v1_q, v2_q, v3_q, v4_q;
  logic [hla_pkg::ANG_W-1:0] a1_q, a2_q;
  logic signed [hla_pkg::TRIG_W-1:0] sin1_q, cos1_q;
  logic signed [hla_pkg::PROD_W-1:0] px2_q, py2_q;
  logic [hla_pkg::ADDR_W-1:0] addr3_q, addr4_q;
  logic [hla_pkg::DEG_W-1:0] deg, cdeg;
  logic signed [hla_pkg::SUM_W-1:0] sum;
  logic signed [hla_pkg::R_W-1:0] rr;
  logic signed [hla_pkg::BIN_W-1:0] bin;
  logic bin_ok;

  logic ram_we, ram_re;
  logic [hla_pkg::ADDR_W-1:0] ram_wa, ram_ra;
  logic [hla_pkg::COUNT_BITS-1:0] ram_wd, ram_rd;

  hla_ram #(
    .WIDTH(hla_pkg::COUNT_BITS),
    .DEPTH(hla_pkg::STORE_CELLS)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_wa),
    .wr_data_i (ram_wd),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_ra),
    .rd_data_o (ram_rd)
  );

  always_comb begin
    deg  = hla_pkg::DEG_W'(ang_q);
    cdeg = deg + hla_pkg::DEG_W'(90);
    if (cdeg >= hla_pkg::DEG_W'(360)) cdeg = cdeg - hla_pkg::DEG_W'(360);
    sum = hla_pkg::SUM_W'(px2_q) + hla_pkg::SUM_W'(py2_q);
    // truncate toward zero
    rr  = hla_pkg::R_W'((sum + (sum < 0 ? hla_pkg::SUM_W'(16383) : '0)) >>> 14);
    bin = $signed({{(hla_pkg::BIN_W-hla_pkg::HD_W){1'b0}}, cfg_i.hdiag}) +
          hla_pkg::BIN_W'(rr);
    bin_ok = (bin >= 0) &&
             (bin <= $signed({{(hla_pkg::BIN_W-hla_pkg::HD_W-1){1'b0}}, cfg_i.hdiag, 1'b0})) &&
             (32'(bin) < 32'(hla_pkg::RHO_BINS));
  end

  always_comb begin
    state_d   = state_q;
    ang_d     = ang_q;
    clr_d     = clr_q;
    clr_res_d = clr_res_q;
    init_d    = init_q;
    res_vld_d = 1'b0;
    res_cnt_d = '0;
    res_rv_d  = 1'b0;
    take      = 1'b0;
    issue     = 1'b0;
    ram_we    = v4_q;
    ram_wa    = addr4_q;
    ram_wd    = (ram_rd == hla_pkg::COUNT_MAX) ? ram_rd : ram_rd + 1'b1;
    ram_re    = v3_q;
    ram_ra    = addr3_q;
    unique case (state_q)
      hla_pkg::ST_IDLE: begin
        if (ent_vld_i) begin
          take = 1'b1;
          unique case (ent_i.op)
            hla_pkg::OP_VOTE: begin
              state_d = hla_pkg::ST_VOTE;
              ang_d   = '0;
            end
            hla_pkg::OP_READ:  state_d = hla_pkg::ST_READ;
            hla_pkg::OP_CLEAR: begin
              state_d   = hla_pkg::ST_CLEAR;
              clr_d     = '0;
              clr_res_d = 1'b1;
            end
            default: res_vld_d = 1'b1;
          endcase
        end
      end
      hla_pkg::ST_VOTE: begin
        issue = 1'b1;
        if (32'(ang_q) == 32'(hla_pkg::NUM_ANGLES - 1)) begin
          state_d = hla_pkg::ST_DRAIN;
        end else begin
          ang_d = ang_q + 1'b1;
        end
      end
      hla_pkg::ST_DRAIN: begin
        // wait for the last write-back
        if (!(v1_q || v2_q || v3_q || v4_q)) begin
          res_vld_d = 1'b1;
          state_d   = hla_pkg::ST_IDLE;
        end
      end
      hla_pkg::ST_READ: begin
        ram_re  = 1'b1;
        ram_ra  = cur_q.addr;
        state_d = hla_pkg::ST_RDWAIT;
      end
      hla_pkg::ST_RDWAIT: begin
        res_vld_d = 1'b1;
        res_cnt_d = ram_rd;
        res_rv_d  = 1'b1;
        state_d   = hla_pkg::ST_IDLE;
      end
      hla_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        ram_wa = clr_q;
        ram_wd = '0;
        if (32'(clr_q) == 32'(hla_pkg::STORE_CELLS - 1)) begin
          res_vld_d = clr_res_q;
          init_d    = 1'b0;
          state_d   = hla_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      default: state_d = hla_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= hla_pkg::ST_CLEAR;
      ang_q     <= '0;
      clr_q     <= '0;
      clr_res_q <= 1'b0;
      init_q    <= 1'b1;
      res_vld_q <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      ang_q     <= ang_d;
      clr_q     <= clr_d;
      clr_res_q <= clr_res_d;
      init_q    <= init_d;
      res_vld_q <= res_vld_d;
      v1_q      <= issue;
      v2_q      <= v1_q;
      v3_q      <= v2_q && bin_ok;
      v4_q      <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) cur_q <= ent_i;
    res_cnt_q <= res_cnt_d;
    res_rv_q  <= res_rv_d;
    a1_q      <= ang_q;
    sin1_q    <= hla_pkg::sine_q14(deg);
    cos1_q    <= hla_pkg::sine_q14(cdeg);
    a2_q      <= a1_q;
    px2_q     <= hla_pkg::PROD_W'(cur_q.dx * sin1_q);
    py2_q     <= hla_pkg::PROD_W'(cur_q.dy * cos1_q);
    addr3_q   <= hla_pkg::ADDR_W'(a2_q) * hla_pkg::ADDR_W'(hla_pkg::RHO_BINS)
               + hla_pkg::ADDR_W'(bin);
    addr4_q   <= addr3_q;
  end

  assign stat_o.ready = (state_q == hla_pkg::ST_IDLE);
  assign stat_o.init  = init_q;
  assign done_o       = res_vld_q;
  assign cell_count_o = res_cnt_q;
  assign read_valid_o = res_rv_q;

endmodule

// ===== hdl/hough_line_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// hough_line_accumulator_core: Hough line vote accumulator
// Channel  | handshake               | payload
// command  | start_i / busy_o        | kind, col, row, pixel_value, angle, rho
// result   | done_o strobe           | cell_count_o, read_valid_o
// config   | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
// A vote makes one read-modify-write of the store per angle in the back
// end; a read fetches one cell, and a clear writes one store cell per
// cycle. After reset a clearing pass over the store holds busy_o high.
// A two-entry queue lets commands be taken while the back end works.
// ----------------------------------------------------------------------------
module hough_line_accumulator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [1:0]                     kind_i,
  input  logic [8:0]                     col_i,
  input  logic [8:0]                     row_i,
  input  logic [7:0]                     pixel_value_i,
  input  logic [7:0]                     angle_index_i,
  input  logic [9:0]                     rho_index_i,
  output logic                           done_o,
  output logic [hla_pkg::COUNT_BITS-1:0] cell_count_o,
  output logic                           read_valid_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_index_i,
  input  logic [hla_pkg::DIM_W-1:0]      cfg_data_i
);

  hla_pkg::cfg_t       cfg_q;
  hla_pkg::back_stat_t stat;
  hla_pkg::entry_t     ent;
  logic                ent_vld;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= hla_pkg::DIM_W'(512);
      cfg_q.height <= hla_pkg::DIM_W'(512);
      cfg_q.hdiag  <= hla_pkg::HD_W'(362);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        hla_pkg::REG_WIDTH:  cfg_q.width  <= cfg_data_i;
        hla_pkg::REG_HEIGHT: cfg_q.height <= cfg_data_i;
        hla_pkg::REG_HDIAG:  cfg_q.hdiag  <= cfg_data_i[hla_pkg::HD_W-1:0];
        default: ;
      endcase
    end
  end

  hla_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .stat_i        (stat),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .kind_i        (kind_i),
    .col_i         (col_i),
    .row_i         (row_i),
    .pixel_value_i (pixel_value_i),
    .angle_index_i (angle_index_i),
    .rho_index_i   (rho_index_i),
    .ent_vld_o     (ent_vld),
    .ent_o         (ent)
  );

  hla_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .ent_vld_i    (ent_vld),
    .ent_i        (ent),
    .stat_o       (stat),
    .done_o       (done_o),
    .cell_count_o (cell_count_o),
    .read_valid_o (read_valid_o)
  );

endmodule
